>>> hw/rtl/c2dvs_pkg.sv
// Shared constants for the streaming 2D valid correlation block.
// Register indexes and fixed field widths; no dependencies.
package c2dvs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned SumW     = 40;
  localparam int unsigned RowW     = 12;
  localparam int unsigned ColW     = 10;
  localparam int unsigned MaxImageRows = 4096;

  localparam logic [CfgIdxW-1:0] RegImageRows  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageCols  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFilterRows = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFilterCols = 3'd3;

  localparam logic OpCoef  = 1'b0;
  localparam logic OpPixel = 1'b1;

endpackage

>>> hw/rtl/conv2d_valid_stream.sv
// Top level of the streaming 2D valid correlation block.
// Line store, coefficient store and a one-tap-per-cycle multiply-accumulate.
// Depends on c2dvs_pkg.

// A coefficient beat, or a pixel beat that completes no window, is taken
// without a stall. One that completes a window stalls the input, since
// the taps are read one per cycle from the single read port of the line store
// and coefficient store and summed by one shared multiply-accumulate unit.
// The result waits in an output register, so the next beat is taken while it
// is pending. Configuration is taken only while no window is being summed.
module conv2d_valid_stream #(
  parameter int unsigned MAX_COLS        = 1024,
  parameter int unsigned MAX_FILTER_ROWS = 7,
  parameter int unsigned MAX_FILTER_COLS = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [c2dvs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [c2dvs_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic signed [c2dvs_pkg::ValueW-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [c2dvs_pkg::SumW-1:0]    sum_o,
  output logic [c2dvs_pkg::RowW-1:0]           out_row_o,
  output logic [c2dvs_pkg::ColW-1:0]           out_col_o,
  output logic                                 last_o
);

  localparam int unsigned NCoef = MAX_FILTER_ROWS * MAX_FILTER_COLS;
  localparam int unsigned NLine = MAX_FILTER_ROWS * MAX_COLS;
  localparam int unsigned LAW   = $clog2(NLine);
  localparam int unsigned CAW   = (NCoef > 1) ? $clog2(NCoef) : 1;
  localparam int unsigned CCW   = $clog2(NCoef + 1);
  localparam int unsigned SW    = (MAX_FILTER_ROWS > 1) ? $clog2(MAX_FILTER_ROWS) : 1;
  localparam int unsigned FRW   = $clog2(MAX_FILTER_ROWS + 1);
  localparam int unsigned FCW   = $clog2(MAX_FILTER_COLS + 1);
  localparam int unsigned NW    = FRW + FCW;
  localparam int unsigned PCW   = $clog2(MAX_COLS);
  localparam int unsigned CW1   = $clog2(MAX_COLS + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0] state_q, state_d;

  logic [12:0] cfg_rows_q;
  logic [10:0] cfg_cols_q;
  logic [2:0]  cfg_fr_q, cfg_fc_q;

  logic [12:0]    rows_eff;
  logic [CW1-1:0] cols_eff;
  logic [FRW-1:0] fr_eff;
  logic [FCW-1:0] fc_eff;

  always_comb begin
    if (cfg_rows_q == 13'd0) rows_eff = 13'd1;
    else if (cfg_rows_q > 13'(c2dvs_pkg::MaxImageRows)) rows_eff = 13'(c2dvs_pkg::MaxImageRows);
    else rows_eff = cfg_rows_q;
    if (cfg_cols_q == 11'd0) cols_eff = CW1'(1);
    else if (13'(cfg_cols_q) > 13'(MAX_COLS)) cols_eff = CW1'(MAX_COLS);
    else cols_eff = CW1'(cfg_cols_q);
    if (cfg_fr_q == 3'd0) fr_eff = FRW'(1);
    else if (4'(cfg_fr_q) > 4'(MAX_FILTER_ROWS)) fr_eff = FRW'(MAX_FILTER_ROWS);
    else fr_eff = FRW'(cfg_fr_q);
    if (cfg_fc_q == 3'd0) fc_eff = FCW'(1);
    else if (4'(cfg_fc_q) > 4'(MAX_FILTER_COLS)) fc_eff = FCW'(MAX_FILTER_COLS);
    else fc_eff = FCW'(cfg_fc_q);
  end

  logic cfg_we, cfg_hit, in_acc, pix_acc, coef_acc;
  assign cfg_ready_o = (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && (cfg_index_i inside {c2dvs_pkg::RegImageRows,
                       c2dvs_pkg::RegImageCols, c2dvs_pkg::RegFilterRows,
                       c2dvs_pkg::RegFilterCols});
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pix_acc     = in_acc && (operation_i == c2dvs_pkg::OpPixel);
  assign coef_acc    = in_acc && (operation_i == c2dvs_pkg::OpCoef);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows_q <= 13'd1;
      cfg_cols_q <= 11'd1;
      cfg_fr_q   <= 3'd1;
      cfg_fc_q   <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        c2dvs_pkg::RegImageRows:  cfg_rows_q <= cfg_data_i;
        c2dvs_pkg::RegImageCols:  cfg_cols_q <= cfg_data_i[10:0];
        c2dvs_pkg::RegFilterRows: cfg_fr_q   <= cfg_data_i[2:0];
        c2dvs_pkg::RegFilterCols: cfg_fc_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [c2dvs_pkg::RowW-1:0] prow_q, prow_d;
  logic [PCW-1:0]             pcol_q, pcol_d;
  logic [SW-1:0]              slot_q, slot_d;
  logic [CCW-1:0]             ccnt_q, ccnt_d;

  logic [12:0]    row_p1;
  logic [PCW:0]   col_p1;
  logic           win_hit, coef_room;
  logic [4:0]     bslot_w;
  logic [SW-1:0]  bslot;
  logic [c2dvs_pkg::RowW-1:0] win_i;
  logic [PCW-1:0] win_j;

  always_comb begin
    row_p1    = 13'(prow_q) + 13'd1;
    col_p1    = (PCW + 1)'(pcol_q) + (PCW + 1)'(1);
    win_hit   = (row_p1 >= 13'(fr_eff)) && (col_p1 >= (PCW + 1)'(fc_eff));
    win_i     = c2dvs_pkg::RowW'(row_p1 - 13'(fr_eff));
    win_j     = PCW'(col_p1 - (PCW + 1)'(fc_eff));
    coef_room = NW'(ccnt_q) < (NW'(fr_eff) * NW'(fc_eff));
    if (5'(slot_q) >= 5'(fr_eff) - 5'd1) bslot_w = 5'(slot_q) - (5'(fr_eff) - 5'd1);
    else bslot_w = 5'(slot_q) + 5'(MAX_FILTER_ROWS) - (5'(fr_eff) - 5'd1);
    bslot = SW'(bslot_w);

    prow_d = prow_q;
    pcol_d = pcol_q;
    slot_d = slot_q;
    ccnt_d = ccnt_q;
    if (cfg_hit) begin
      prow_d = '0;
      pcol_d = '0;
      slot_d = '0;
      ccnt_d = '0;
    end else if (coef_acc) begin
      if (coef_room) ccnt_d = ccnt_q + CCW'(1);
    end else if (pix_acc) begin
      ccnt_d = '0;
      if (CW1'(col_p1) >= cols_eff) begin
        pcol_d = '0;
        if (row_p1 >= rows_eff) begin
          prow_d = '0;
          slot_d = '0;
        end else begin
          prow_d = row_p1[c2dvs_pkg::RowW-1:0];
          slot_d = (slot_q == SW'(MAX_FILTER_ROWS - 1)) ? '0 : slot_q + SW'(1);
        end
      end else begin
        pcol_d = col_p1[PCW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prow_q <= '0;
      pcol_q <= '0;
      slot_q <= '0;
      ccnt_q <= '0;
    end else begin
      prow_q <= prow_d;
      pcol_q <= pcol_d;
      slot_q <= slot_d;
      ccnt_q <= ccnt_d;
    end
  end

  // tap sequencer
  logic [FRW-1:0] k_q;
  logic [FCW-1:0] s_q;
  logic [SW-1:0]  rs_q;
  logic [CAW-1:0] cidx_q;
  logic [PCW-1:0] j_q;
  logic [c2dvs_pkg::RowW-1:0] mi_q;
  logic           mlast_q;
  logic           issuing, tap_last, row_end;
  logic [LAW-1:0] raddr, waddr;

  assign issuing  = (state_q == StIssue);
  assign row_end  = (s_q == fc_eff - FCW'(1));
  assign tap_last = row_end && (k_q == fr_eff - FRW'(1));
  assign raddr    = LAW'(rs_q) * LAW'(MAX_COLS) + LAW'(j_q) + LAW'(s_q);
  assign waddr    = LAW'(slot_q) * LAW'(MAX_COLS) + LAW'(pcol_q);

  always_ff @(posedge clk_i) begin
    if (pix_acc && !cfg_hit) begin
      k_q     <= '0;
      s_q     <= '0;
      rs_q    <= bslot;
      cidx_q  <= '0;
      j_q     <= win_j;
      mi_q    <= win_i;
      mlast_q <= (row_p1 == rows_eff) && (CW1'(col_p1) == cols_eff);
    end else if (issuing) begin
      cidx_q <= cidx_q + CAW'(1);
      if (row_end) begin
        s_q  <= '0;
        k_q  <= k_q + FRW'(1);
        rs_q <= (rs_q == SW'(MAX_FILTER_ROWS - 1)) ? '0 : rs_q + SW'(1);
      end else begin
        s_q <= s_q + FCW'(1);
      end
    end
  end

  logic signed [c2dvs_pkg::ValueW-1:0] lmem [NLine];
  logic signed [c2dvs_pkg::ValueW-1:0] cmem [NCoef];
  logic signed [c2dvs_pkg::ValueW-1:0] line_q, coef_q;

  always_ff @(posedge clk_i) begin
    if (pix_acc && !cfg_hit) lmem[waddr] <= value_i;
    line_q <= lmem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (coef_acc && !cfg_hit && coef_room) cmem[ccnt_q[CAW-1:0]] <= value_i;
    coef_q <= cmem[cidx_q];
  end

  logic rd_v_q, rd_last_q, pr_v_q, pr_last_q, fin_q;
  logic signed [31:0] prod_q;
  logic signed [c2dvs_pkg::SumW-1:0] acc_q;
  logic out_load;

  assign out_load = (state_q == StDrain) && fin_q && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      pr_v_q    <= 1'b0;
      pr_last_q <= 1'b0;
      fin_q     <= 1'b0;
    end else begin
      rd_v_q    <= issuing;
      rd_last_q <= issuing && tap_last;
      pr_v_q    <= rd_v_q;
      pr_last_q <= rd_last_q;
      if (pr_last_q) fin_q <= 1'b1;
      else if (out_load) fin_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 32'(line_q) * 32'(coef_q);
    if (pix_acc) acc_q <= '0;
    else if (pr_v_q) acc_q <= acc_q + {{(c2dvs_pkg::SumW - 32){prod_q[31]}}, prod_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (pix_acc && !cfg_hit && win_hit) state_d = StIssue;
      StIssue: if (tap_last) state_d = StDrain;
      StDrain: if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (out_load) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sum_o     <= acc_q;
      out_row_o <= mi_q;
      out_col_o <= c2dvs_pkg::ColW'(j_q);
      last_o    <= mlast_q;
    end
  end

endmodule

>>> hw/rtl/c2dvs_checker.sv
// Port-level checks for the streaming 2D valid correlation block.
// Bound to conv2d_valid_stream; depends on c2dvs_pkg.
module c2dvs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [c2dvs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input logic [c2dvs_pkg::CfgDataW-1:0]      cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                operation_i,
  input logic [c2dvs_pkg::ValueW-1:0]        value_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [c2dvs_pkg::SumW-1:0]          sum_o,
  input logic [c2dvs_pkg::RowW-1:0]          out_row_o,
  input logic [c2dvs_pkg::ColW-1:0]          out_col_o,
  input logic                                last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sum_o) && $stable(out_row_o)
      && $stable(out_col_o) && $stable(last_o))
    else $error("stalled result beat changed");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o)
    else $error("configuration taken while a window is in flight");

  a_coef_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == c2dvs_pkg::OpCoef |=> !in_stall_o)
    else $error("coefficient beat stalled the input");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a window being summed");

endmodule

bind conv2d_valid_stream c2dvs_checker u_c2dvs_checker (.*);
